>>> hdl/matrix3_inverse_top_macros.svh
// Assertion macros used by the matrix inverse top level.
`ifndef MATRIX3_INVERSE_TOP_MACROS_SVH
`define MATRIX3_INVERSE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define M3INV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("m3inv check failed");

// Next-cycle implication, checked outside reset.
`define M3INV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("m3inv check failed");

`endif

>>> hdl/m3inv_pkg.sv
package m3inv_pkg;

    // Number of elements in one matrix and in its inverse.
    localparam int NUM_ELEMS = 9;

    typedef logic [3:0] elem_idx_t;

    // Element indexes of the two products that form each adjugate entry:
    // adj = a[i0] * a[i1] - a[i2] * a[i3], row-major order.
    localparam elem_idx_t COF_IDX [NUM_ELEMS][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // Status that travels with each quotient from a divider lane.
    typedef struct packed {
        logic valid;
        logic neg;
        logic sat;
    } div_status_t;

endpackage

>>> hdl/m3inv_cof.sv
module m3inv_cof
    import m3inv_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [W-1:0]  a [NUM_ELEMS],
    output logic                 out_valid,
    output logic [2*W+2*F-1:0]   num_mag [NUM_ELEMS],
    output logic                 num_neg [NUM_ELEMS],
    output logic [3*W-1:0]       det_mag,
    output logic                 singular
);

    localparam int PW = 2 * W;
    localparam int CW = 2 * W + 1;
    localparam int DW = 3 * W + 2;

    logic               v_reg [7];
    logic signed [W-1:0]  a1_reg [NUM_ELEMS];
    logic signed [PW-1:0] p2_reg [NUM_ELEMS];
    logic signed [PW-1:0] q2_reg [NUM_ELEMS];
    logic signed [W-1:0]  r2_reg [3];
    logic signed [W-1:0]  r3_reg [3];
    logic signed [CW-1:0] cof3_reg [NUM_ELEMS];
    logic signed [CW-1:0] cof4_reg [NUM_ELEMS];
    logic signed [CW-1:0] cof5_reg [NUM_ELEMS];
    logic signed [CW-1:0] cof6_reg [NUM_ELEMS];
    logic signed [CW-1:0] plo4_reg [3];
    logic signed [CW-1:0] phi4_reg [3];
    logic signed [DW-1:0] t5_reg [3];
    logic signed [DW-1:0] det6_reg;
    logic [2*W+2*F-1:0]   num7_reg [NUM_ELEMS];
    logic                 neg7_reg [NUM_ELEMS];
    logic [3*W-1:0]       det7_reg;
    logic                 sing7_reg;

    logic signed [DW-1:0] det_abs;
    logic                 det_neg;
    logic signed [CW-1:0] cof_abs [NUM_ELEMS];

    // Valid bits of the seven front-end stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 7; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < 7; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    // Magnitudes and signs for the dividers.
    always_comb
    begin
        det_neg = det6_reg[DW-1];
        det_abs = det_neg ? -det6_reg : det6_reg;
        for (int i = 0; i < NUM_ELEMS; i++)
        begin
            cof_abs[i] = cof6_reg[i][CW-1] ? -cof6_reg[i] : cof6_reg[i];
        end
    end

    // Datapath: products, cofactors, determinant partials, sum, magnitudes.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_ELEMS; i++)
        begin
            a1_reg[i]   <= a[i];
            p2_reg[i]   <= PW'(a1_reg[COF_IDX[i][0]]) * PW'(a1_reg[COF_IDX[i][1]]);
            q2_reg[i]   <= PW'(a1_reg[COF_IDX[i][2]]) * PW'(a1_reg[COF_IDX[i][3]]);
            cof3_reg[i] <= CW'(p2_reg[i]) - CW'(q2_reg[i]);
            cof4_reg[i] <= cof3_reg[i];
            cof5_reg[i] <= cof4_reg[i];
            cof6_reg[i] <= cof5_reg[i];
            num7_reg[i] <= {cof_abs[i][PW-1:0], {(2*F){1'b0}}};
            neg7_reg[i] <= cof6_reg[i][CW-1] ^ det_neg;
        end
        for (int j = 0; j < 3; j++)
        begin
            r2_reg[j]   <= a1_reg[j];
            r3_reg[j]   <= r2_reg[j];
            // Row 0 times the first adjugate column, split in two halves.
            plo4_reg[j] <= CW'(r3_reg[j]) * CW'($signed({1'b0, cof3_reg[3*j][W-1:0]}));
            phi4_reg[j] <= CW'(r3_reg[j]) * CW'($signed(cof3_reg[3*j][CW-1:W]));
            t5_reg[j]   <= (DW'(phi4_reg[j]) <<< W) + DW'(plo4_reg[j]);
        end
        det6_reg  <= t5_reg[0] + t5_reg[1] + t5_reg[2];
        det7_reg  <= det_abs[3*W-1:0];
        sing7_reg <= (det6_reg == '0);
    end

    assign out_valid = v_reg[6];
    assign num_mag   = num7_reg;
    assign num_neg   = neg7_reg;
    assign det_mag   = det7_reg;
    assign singular  = sing7_reg;

endmodule

>>> hdl/m3inv_div_lane.sv
module m3inv_div_lane
    import m3inv_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [2*W+2*F-1:0] num,
    input  logic [3*W-1:0]     den,
    input  logic               neg,
    output div_status_t        status,
    output logic [W-1:0]       quo
);

    localparam int NW = 2 * W + 2 * F;
    localparam int DMW = 3 * W;
    localparam int XW = (NW > DMW + W) ? NW : DMW + W;

    logic          v_reg   [W+1];
    logic          neg_reg [W+1];
    logic          sat_reg [W+1];
    logic [NW-1:0] rem_reg [W+1];
    logic [DMW-1:0] d_reg  [W+1];
    logic [W-1:0]  q_reg   [W+1];

    // Valid bits, one per stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= W; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= W; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    // First stage: a quotient of 2^W or more saturates either way.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num;
        d_reg[0]   <= den;
        neg_reg[0] <= neg;
        q_reg[0]   <= '0;
        sat_reg[0] <= (XW'(num) >= (XW'(den) << W));
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 1; s <= W; s++)
    begin : g_stage
        localparam int K = W - s;
        logic [XW:0]   diff;
        logic          take;
        logic [W-1:0]  q_next;
        logic [NW-1:0] rem_next;

        always_comb
        begin
            diff     = {1'b0, XW'(rem_reg[s-1])} - {1'b0, XW'(d_reg[s-1]) << K};
            take     = ~diff[XW];
            q_next   = q_reg[s-1];
            q_next[K] = take;
            rem_next = take ? diff[NW-1:0] : rem_reg[s-1];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            q_reg[s]   <= q_next;
            d_reg[s]   <= d_reg[s-1];
            neg_reg[s] <= neg_reg[s-1];
            sat_reg[s] <= sat_reg[s-1];
        end
    end

    assign status = '{valid: v_reg[W], neg: neg_reg[W], sat: sat_reg[W]};
    assign quo    = q_reg[W];

endmodule

>>> hdl/m3inv_merge.sv
module m3inv_merge
    import m3inv_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  div_status_t  status [NUM_ELEMS],
    input  logic [W-1:0] quo [NUM_ELEMS],
    input  logic         singular_in,
    output logic         done,
    output logic [W-1:0] res [NUM_ELEMS],
    output logic         singular
);

    localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

    logic         done_reg;
    logic         sing_reg;
    logic [W-1:0] res_reg  [NUM_ELEMS];
    logic [W-1:0] res_next [NUM_ELEMS];

    // Sign, saturation and the singular override for every lane.
    always_comb
    begin
        for (int i = 0; i < NUM_ELEMS; i++)
        begin
            if (singular_in)
            begin
                res_next[i] = '0;
            end
            else if (status[i].neg)
            begin
                res_next[i] = (status[i].sat || (quo[i] > MIN_VAL)) ? MIN_VAL : -quo[i];
            end
            else
            begin
                res_next[i] = (status[i].sat || quo[i][W-1]) ? MAX_VAL : quo[i];
            end
        end
    end

    // Result strobe and flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            sing_reg <= 1'b0;
        end
        else
        begin
            done_reg <= status[0].valid;
            sing_reg <= status[0].valid & singular_in;
        end
    end

    // Result elements.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_ELEMS; i++)
        begin
            res_reg[i] <= res_next[i];
        end
    end

    assign done     = done_reg;
    assign singular = sing_reg;
    assign res      = res_reg;

endmodule

>>> hdl/matrix3_inverse_top.sv
// 3x3 matrix inverse by the adjugate, fully pipelined.
// From start to done, each request passes through:
// seven front-end stages, ELEM_WIDTH + 1 divider stages, one output register.
// Throughput: one matrix per cycle; busy is always low and done cannot be held off.
// Reset: rst_n clears all valid bits at once; requests in flight are dropped.
module matrix3_inverse_top
    import m3inv_pkg::*;
#(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [ELEM_WIDTH-1:0] m00,
    input  logic signed [ELEM_WIDTH-1:0] m01,
    input  logic signed [ELEM_WIDTH-1:0] m02,
    input  logic signed [ELEM_WIDTH-1:0] m10,
    input  logic signed [ELEM_WIDTH-1:0] m11,
    input  logic signed [ELEM_WIDTH-1:0] m12,
    input  logic signed [ELEM_WIDTH-1:0] m20,
    input  logic signed [ELEM_WIDTH-1:0] m21,
    input  logic signed [ELEM_WIDTH-1:0] m22,
    output logic                         done,
    output logic signed [ELEM_WIDTH-1:0] r00,
    output logic signed [ELEM_WIDTH-1:0] r01,
    output logic signed [ELEM_WIDTH-1:0] r02,
    output logic signed [ELEM_WIDTH-1:0] r10,
    output logic signed [ELEM_WIDTH-1:0] r11,
    output logic signed [ELEM_WIDTH-1:0] r12,
    output logic signed [ELEM_WIDTH-1:0] r20,
    output logic signed [ELEM_WIDTH-1:0] r21,
    output logic signed [ELEM_WIDTH-1:0] r22,
    output logic                         singular
);

`include "matrix3_inverse_top_macros.svh"

    localparam int W = ELEM_WIDTH;
    localparam int NW = 2 * ELEM_WIDTH + 2 * FRAC_BITS;
    localparam int LATENCY = ELEM_WIDTH + 9;

    logic signed [W-1:0] a [NUM_ELEMS];
    logic                fe_valid;
    logic [NW-1:0]       num_mag [NUM_ELEMS];
    logic                num_neg [NUM_ELEMS];
    logic [3*W-1:0]      det_mag;
    logic                fe_singular;
    div_status_t         status [NUM_ELEMS];
    logic [W-1:0]        quo [NUM_ELEMS];
    logic [W-1:0]        res [NUM_ELEMS];
    logic                sing_reg [W+1];

    // The pipeline takes a request every cycle.
    assign busy = 1'b0;

    assign a = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};

    // Cofactors, determinant and magnitudes.
    m3inv_cof #(.W(W), .F(FRAC_BITS)) u_cof (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .a        (a),
        .out_valid(fe_valid),
        .num_mag  (num_mag),
        .num_neg  (num_neg),
        .det_mag  (det_mag),
        .singular (fe_singular)
    );

    // Nine divider lanes, one per inverse element.
    for (genvar i = 0; i < NUM_ELEMS; i++)
    begin : g_lane
        m3inv_div_lane #(.W(W), .F(FRAC_BITS)) u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .in_valid(fe_valid),
            .num     (num_mag[i]),
            .den     (det_mag),
            .neg     (num_neg[i]),
            .status  (status[i]),
            .quo     (quo[i])
        );
    end

    // Singular flag delayed to line up with the divider outputs.
    always_ff @(posedge clk)
    begin
        sing_reg[0] <= fe_singular;
        for (int s = 1; s <= W; s++)
        begin
            sing_reg[s] <= sing_reg[s-1];
        end
    end

    // Final sign handling and output register.
    m3inv_merge #(.W(W)) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .status     (status),
        .quo        (quo),
        .singular_in(sing_reg[W]),
        .done       (done),
        .res        (res),
        .singular   (singular)
    );

    assign r00 = res[0];
    assign r01 = res[1];
    assign r02 = res[2];
    assign r10 = res[3];
    assign r11 = res[4];
    assign r12 = res[5];
    assign r20 = res[6];
    assign r21 = res[7];
    assign r22 = res[8];

    // Every request yields its result after the fixed latency.
    `M3INV_ASSERT_NOW(a_latency, clk, rst_n, start, ##LATENCY done)
    // The singular flag only appears with a result strobe.
    `M3INV_ASSERT_NOW(a_sing_done, clk, rst_n, singular, done)
    // A singular result carries zero elements (checked on r00, r11, r22, r01, r12 and r20).
    `M3INV_ASSERT_NOW(a_sing_zero, clk, rst_n, singular,
        r00 == '0 && r11 == '0 && r22 == '0 && r01 == '0 && r12 == '0 && r20 == '0)
    // Lanes run in lock step.
    `M3INV_ASSERT_NOW(a_lanes, clk, rst_n, status[0].valid,
        status[4].valid && status[8].valid)
    // A front-end output reaches the divider outputs after the divider stages.
    `M3INV_ASSERT_NEXT(a_front, clk, rst_n, fe_valid, ##W status[0].valid)

endmodule
